>>> sv/point_segment_projection_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for point_segment_projection
// Clocked checks on clk_i, masked while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef POINT_SEGMENT_PROJECTION_ASSERT_SVH
`define POINT_SEGMENT_PROJECTION_ASSERT_SVH
`ifndef SYNTH
// Consequent must hold in the cycle after the antecedent
`define PSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("point_segment_projection: check failed");
// Consequent must hold in the same cycle as the antecedent
`define PSP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("point_segment_projection: check failed");
`else
`define PSP_ASSERT_NEXT(lbl, ante, cons)
`define PSP_ASSERT_SAME(lbl, ante, cons)
`endif
`endif

>>> sv/psp_pkg.sv
// ----------------------------------------------------------------------------
// psp_pkg
// Beat types and defaults for the point to segment projection pipeline.
// ----------------------------------------------------------------------------
package psp_pkg;

  // Default coordinate width in bits (16.16 fixed point)
  localparam int CoordWidthDef = 32;

  // Query beat
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
  } psp_in_t;

  // Result beat
  typedef struct packed {
    logic signed [31:0] proj_x;
    logic signed [31:0] proj_y;
  } psp_out_t;

endpackage

>>> sv/point_segment_projection.sv
// ----------------------------------------------------------------------------
// point_segment_projection
// Nearest point on a line segment, exact integer foot of perpendicular.
// ----------------------------------------------------------------------------
// Takes one query beat per cycle while in_stall_o is low and returns one result
// beat per query, in order. The restoring divider resolves one quotient bit
// per pipeline stage; the stages ahead of it form the squares, split products
// and the exact numerator, and two stages behind it saturate and clamp to the
// segment end points. A stall on the result side freezes the whole pipeline,
// and in_stall_o follows it in the same cycle.
module point_segment_projection
  import psp_pkg::*;
#(
  parameter int COORD_WIDTH = CoordWidthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  psp_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output psp_out_t out_data_o
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = 2 * W;
  localparam int PW = 2 * W + 2;
  localparam int NW = 3 * W + 2;
  localparam int HW = NW - W;
  localparam logic [W-1:0] QLim = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] QMax = {1'b0, {(W-1){1'b1}}};

  // One quotient bit: returns {next remainder, quotient bit}
  function automatic logic [DW:0] div_step(logic [DW-1:0] rem, logic nbit,
                                           logic [DW-1:0] den);
    logic [DW:0] trial;
    logic [DW:0] diff;
    trial = {rem, nbit};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      return {diff[DW-1:0], 1'b1};
    end
    return {trial[DW-1:0], 1'b0};
  endfunction

  logic en;

  logic signed [W-1:0] pt_in [2];
  logic signed [W-1:0] st_in [2];
  logic signed [W-1:0] dl_in [2];

  // Stage 1: squares and cross product
  logic                vld1_q;
  logic signed [W-1:0] pt1_q [2];
  logic signed [W-1:0] st1_q [2];
  logic signed [W-1:0] dl1_q [2];
  logic signed [W:0]   off1_q [2];
  logic signed [DW-1:0] sq1_q [2];
  logic signed [DW-1:0] cross1_q;

  // Stage 2: split partial products
  logic                vld2_q;
  logic signed [W-1:0] st2_q [2];
  logic signed [W-1:0] dl2_q [2];
  logic signed [PW-1:0] plo2_q [2];
  logic signed [PW-1:0] phi2_q [2];
  logic signed [PW-1:0] slo2_q [2];
  logic signed [PW-1:0] shi2_q [2];
  logic signed [PW-1:0] clo2_q [2];
  logic signed [PW-1:0] chi2_q [2];
  logic [DW-1:0]       den2_q;
  logic                zero2_q;

  // Stage 3: full products
  logic                vld3_q;
  logic signed [W-1:0] st3_q [2];
  logic signed [W-1:0] dl3_q [2];
  logic signed [NW-1:0] tp3_q [2];
  logic signed [NW-1:0] ts3_q [2];
  logic signed [NW-1:0] tc3_q [2];
  logic [DW-1:0]       den3_q;
  logic                zero3_q;

  // Stage 4: numerator
  logic                vld4_q;
  logic signed [W-1:0] st4_q [2];
  logic signed [W-1:0] dl4_q [2];
  logic signed [NW-1:0] num4_q [2];
  logic [DW-1:0]       den4_q;
  logic                zero4_q;

  // Stage 5: sign and magnitude
  logic                vld5_q;
  logic signed [W-1:0] st5_q [2];
  logic signed [W-1:0] dl5_q [2];
  logic                neg5_q [2];
  logic [NW-1:0]       mag5_q [2];
  logic [DW-1:0]       den5_q;
  logic                zero5_q;

  // Divider stages, index 0 is the entry
  logic                vdv_q    [0:W];
  logic signed [W-1:0] stdv_q   [0:W][2];
  logic signed [W-1:0] dldv_q   [0:W][2];
  logic [DW-1:0]       dendv_q  [0:W];
  logic                zerodv_q [0:W];
  logic                negdv_q  [0:W][2];
  logic                overdv_q [0:W][2];
  logic [DW-1:0]       remdv_q  [0:W][2];
  logic [W-1:0]        wqdv_q   [0:W][2];
  logic [DW:0]         step_res [0:W-1][2];
  logic [HW-1:0]       hi5 [2];

  // Saturation stage
  logic                vsat_q;
  logic signed [W-1:0] stsat_q [2];
  logic signed [W-1:0] dlsat_q [2];
  logic signed [W-1:0] footsat_q [2];
  logic signed [W-1:0] foot_d [2];

  // Clamp and output
  logic                sel_y;
  logic signed [W-1:0] dsel;
  logic signed [W-1:0] fsel;
  logic signed [W-1:0] ssel;
  logic signed [W-1:0] diff_a;
  logic signed [W-1:0] diff_b;
  logic signed [W-1:0] negd;
  logic                to_start;
  logic                to_end;
  logic signed [W-1:0] res [2];
  logic                out_valid_q;
  psp_out_t            out_data_q;

  // Advance the whole pipeline unless the output beat is held
  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Take the low coordinate bits
  assign pt_in[0] = $signed(in_data_i.point_x[W-1:0]);
  assign pt_in[1] = $signed(in_data_i.point_y[W-1:0]);
  assign st_in[0] = $signed(in_data_i.start_x[W-1:0]);
  assign st_in[1] = $signed(in_data_i.start_y[W-1:0]);
  assign dl_in[0] = $signed(in_data_i.delta_x[W-1:0]);
  assign dl_in[1] = $signed(in_data_i.delta_y[W-1:0]);

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q      <= 1'b0;
      vld2_q      <= 1'b0;
      vld3_q      <= 1'b0;
      vld4_q      <= 1'b0;
      vld5_q      <= 1'b0;
      for (int k = 0; k <= W; k++) begin
        vdv_q[k] <= 1'b0;
      end
      vsat_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld1_q   <= in_valid_i;
      vld2_q   <= vld1_q;
      vld3_q   <= vld2_q;
      vld4_q   <= vld3_q;
      vld5_q   <= vld4_q;
      vdv_q[0] <= vld5_q;
      for (int k = 0; k < W; k++) begin
        vdv_q[k+1] <= vdv_q[k];
      end
      vsat_q      <= vdv_q[W];
      out_valid_q <= vsat_q;
    end
  end

  // Stages 1 to 5: products and numerator
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        pt1_q[a]  <= pt_in[a];
        st1_q[a]  <= st_in[a];
        dl1_q[a]  <= dl_in[a];
        off1_q[a] <= (W+1)'(st_in[a]) - (W+1)'(pt_in[a]);
        sq1_q[a]  <= DW'(dl_in[a]) * DW'(dl_in[a]);
      end
      cross1_q <= DW'(dl_in[0]) * DW'(dl_in[1]);

      for (int a = 0; a < 2; a++) begin
        st2_q[a]  <= st1_q[a];
        dl2_q[a]  <= dl1_q[a];
        plo2_q[a] <= PW'(pt1_q[a]) * PW'($signed({1'b0, sq1_q[a][W-1:0]}));
        phi2_q[a] <= PW'(pt1_q[a]) * PW'($signed(sq1_q[a][DW-1:W]));
        slo2_q[a] <= PW'(st1_q[a]) * PW'($signed({1'b0, sq1_q[1-a][W-1:0]}));
        shi2_q[a] <= PW'(st1_q[a]) * PW'($signed(sq1_q[1-a][DW-1:W]));
        clo2_q[a] <= PW'(off1_q[1-a]) * PW'($signed({1'b0, cross1_q[W-1:0]}));
        chi2_q[a] <= PW'(off1_q[1-a]) * PW'($signed(cross1_q[DW-1:W]));
      end
      den2_q  <= $unsigned(sq1_q[0]) + $unsigned(sq1_q[1]);
      zero2_q <= (dl1_q[0] == '0) && (dl1_q[1] == '0);

      for (int a = 0; a < 2; a++) begin
        st3_q[a] <= st2_q[a];
        dl3_q[a] <= dl2_q[a];
        tp3_q[a] <= NW'(plo2_q[a]) + (NW'(phi2_q[a]) <<< W);
        ts3_q[a] <= NW'(slo2_q[a]) + (NW'(shi2_q[a]) <<< W);
        tc3_q[a] <= NW'(clo2_q[a]) + (NW'(chi2_q[a]) <<< W);
      end
      den3_q  <= den2_q;
      zero3_q <= zero2_q;

      for (int a = 0; a < 2; a++) begin
        st4_q[a]  <= st3_q[a];
        dl4_q[a]  <= dl3_q[a];
        num4_q[a] <= tp3_q[a] + ts3_q[a] - tc3_q[a];
      end
      den4_q  <= den3_q;
      zero4_q <= zero3_q;

      for (int a = 0; a < 2; a++) begin
        st5_q[a]  <= st4_q[a];
        dl5_q[a]  <= dl4_q[a];
        neg5_q[a] <= num4_q[a][NW-1];
        mag5_q[a] <= num4_q[a][NW-1] ? $unsigned(-num4_q[a]) : $unsigned(num4_q[a]);
      end
      den5_q  <= den4_q;
      zero5_q <= zero4_q;
    end
  end

  // Divider step logic, one quotient bit per stage
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      hi5[a] = mag5_q[a][NW-1:W];
    end
    for (int k = 0; k < W; k++) begin
      for (int a = 0; a < 2; a++) begin
        step_res[k][a] = div_step(remdv_q[k][a], wqdv_q[k][a][W-1], dendv_q[k]);
      end
    end
  end

  // Divider pipeline: flag overflow at entry, then shift quotient bits in
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        stdv_q[0][a]   <= st5_q[a];
        dldv_q[0][a]   <= dl5_q[a];
        negdv_q[0][a]  <= neg5_q[a];
        overdv_q[0][a] <= hi5[a] >= HW'(den5_q);
        remdv_q[0][a]  <= hi5[a][DW-1:0];
        wqdv_q[0][a]   <= mag5_q[a][W-1:0];
      end
      dendv_q[0]  <= den5_q;
      zerodv_q[0] <= zero5_q;
      for (int k = 0; k < W; k++) begin
        for (int a = 0; a < 2; a++) begin
          stdv_q[k+1][a]   <= stdv_q[k][a];
          dldv_q[k+1][a]   <= dldv_q[k][a];
          negdv_q[k+1][a]  <= negdv_q[k][a];
          overdv_q[k+1][a] <= overdv_q[k][a];
          remdv_q[k+1][a]  <= step_res[k][a][DW:1];
          wqdv_q[k+1][a]   <= {wqdv_q[k][a][W-2:0], step_res[k][a][0]};
        end
        dendv_q[k+1]  <= dendv_q[k];
        zerodv_q[k+1] <= zerodv_q[k];
      end
    end
  end

  // Saturate the quotient, take the start point for a zero-length segment
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      priority if (zerodv_q[W]) begin
        foot_d[a] = stdv_q[W][a];
      end else if (negdv_q[W][a]) begin
        foot_d[a] = (overdv_q[W][a] || (wqdv_q[W][a] > QLim)) ?
                    $signed(QLim) : $signed(-wqdv_q[W][a]);
      end else begin
        foot_d[a] = (overdv_q[W][a] || (wqdv_q[W][a] > QMax)) ?
                    $signed(QMax) : $signed(wqdv_q[W][a]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        stsat_q[a]   <= stdv_q[W][a];
        dlsat_q[a]   <= dldv_q[W][a];
        footsat_q[a] <= foot_d[a];
      end
    end
  end

  // Clamp to the end points, testing on x unless delta x is zero
  always_comb begin
    sel_y    = (dlsat_q[0] == '0);
    dsel     = sel_y ? dlsat_q[1] : dlsat_q[0];
    fsel     = sel_y ? footsat_q[1] : footsat_q[0];
    ssel     = sel_y ? stsat_q[1] : stsat_q[0];
    diff_a   = fsel - ssel;
    diff_b   = diff_a - dsel;
    negd     = -dsel;
    to_start = diff_a[W-1] ^ dsel[W-1];
    to_end   = diff_b[W-1] ^ negd[W-1];
    for (int a = 0; a < 2; a++) begin
      priority if (to_start) begin
        res[a] = stsat_q[a];
      end else if (to_end) begin
        res[a] = stsat_q[a] + dlsat_q[a];
      end else begin
        res[a] = footsat_q[a];
      end
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q.proj_x <= 32'(res[0]);
      out_data_q.proj_y <= 32'(res[1]);
    end
  end

`include "point_segment_projection_assert.svh"

  // A stall freezes the entry stage
  `PSP_ASSERT_NEXT(a_stall_holds_entry, !en, $stable(vld1_q))
  // An accepted beat occupies the entry stage next cycle
  `PSP_ASSERT_NEXT(a_accept_enters, in_valid_i && !in_stall_o, vld1_q)
  // A finished beat in the saturation stage reaches the output
  `PSP_ASSERT_NEXT(a_sat_to_out, vsat_q && en, out_valid_q)
  // Draining the output frees the input side
  `PSP_ASSERT_SAME(a_drain_accepts, out_valid_o && !out_stall_i, !in_stall_o)

endmodule

>>> verif/point_segment_projection_tb.sv
// ----------------------------------------------------------------------------
// point_segment_projection_tb
// Checks the nearest-point pipeline against an exact integer projection.
// Directed extremes first, then random queries with random idling on both
// sides; every result beat is compared in order with the predicted point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_segment_projection_tb;
  import psp_pkg::*;

  localparam int NumRandom = 950;
  localparam int CycleLimit = 400000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     out_stall_i = 1'b0;
  psp_in_t  in_data_i = '0;
  logic     in_stall_o;
  logic     out_valid_o;
  psp_out_t out_data_o;

  int  error_count = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;
  bit  sending_done = 1'b0;

  // Report one mismatch and count it
  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  // Foot of the perpendicular along one axis, truncated and saturated
  function automatic logic signed [31:0] foot_axis(
      input logic signed [31:0] p, input logic signed [31:0] s,
      input logic signed [31:0] q, input logic signed [31:0] t,
      input logic signed [31:0] dp, input logic signed [31:0] dq);
    logic signed [129:0] num;
    logic signed [129:0] den;
    logic signed [129:0] quo;
    logic signed [129:0] dpsq;
    logic signed [129:0] dqsq;
    dpsq = 130'(dp) * 130'(dp);
    dqsq = 130'(dq) * 130'(dq);
    num = 130'(p) * dpsq + 130'(s) * dqsq
        - (130'(t) - 130'(q)) * 130'(dp) * 130'(dq);
    den = dpsq + dqsq;
    quo = num / den;
    if (quo > 130'sd2147483647) return 32'sh7fffffff;
    if (quo < -130'sd2147483648) return 32'sh80000000;
    return quo[31:0];
  endfunction

  // Nearest point on the segment, clamped with wrapping differences
  function automatic psp_out_t nearest_point(input psp_in_t q);
    psp_out_t r;
    logic signed [31:0] a, b, nd, dir;
    bit to_start, to_end;
    if (q.delta_x == 0 && q.delta_y == 0) begin
      r.proj_x = q.start_x;
      r.proj_y = q.start_y;
    end else begin
      r.proj_x = foot_axis(q.point_x, q.start_x, q.point_y, q.start_y,
                           q.delta_x, q.delta_y);
      r.proj_y = foot_axis(q.point_y, q.start_y, q.point_x, q.start_x,
                           q.delta_y, q.delta_x);
    end
    if (q.delta_x != 0) begin
      a = r.proj_x - q.start_x;
      dir = q.delta_x;
    end else begin
      a = r.proj_y - q.start_y;
      dir = q.delta_y;
    end
    b = a - dir;
    nd = -dir;
    to_start = a[31] != dir[31];
    to_end = b[31] != nd[31];
    if (to_start) begin
      r.proj_x = q.start_x;
      r.proj_y = q.start_y;
    end else if (to_end) begin
      r.proj_x = q.start_x + q.delta_x;
      r.proj_y = q.start_y + q.delta_y;
    end
    return r;
  endfunction

  // Holds predicted points in order and checks each result beat
  class projection_board;
    psp_out_t pending[$];
    int checked = 0;

    function void note_query(psp_in_t q);
      pending.push_back(nearest_point(q));
    endfunction

    task check_point(psp_out_t got);
      psp_out_t want;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat %h", got));
        return;
      end
      want = pending.pop_front();
      if (got.proj_x !== want.proj_x)
        report($sformatf("proj_x got %h want %h", got.proj_x, want.proj_x));
      if (got.proj_y !== want.proj_y)
        report($sformatf("proj_y got %h want %h", got.proj_y, want.proj_y));
    endtask
  endclass

  projection_board board = new();

  point_segment_projection u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sample accepted beats on both sides
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && in_valid_i && !in_stall_o) board.note_query(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) board.check_point(out_data_o);
  end

  // Random stall bursts on the result side
  initial begin
    int n;
    @(posedge rst_ni);
    while (!sending_done || board.pending.size() != 0) begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 10);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      n = $urandom_range(1, 10);
      repeat (n) @(posedge clk_i);
    end
  end

  // Send one query beat, holding it until accepted
  task automatic send_query(input psp_in_t q);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= q;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      1: return 32'($signed($urandom_range(0, 64)) - 32);
      2: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'h20000);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    psp_in_t q;
    psp_in_t seeds[$];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero direction, extremes, clamp to either end, saturation
    seeds.push_back('{32'h10000, 32'h20000, 0, 0, 0, 0});
    seeds.push_back('{32'h50000, 32'h50000, 0, 0, 32'h10000, 32'h10000});
    seeds.push_back('{-32'sh50000, 32'h0, 0, 0, 32'h10000, 32'h10000});
    seeds.push_back('{32'h80000, 32'h10000, 0, 0, 32'h20000, 0});
    seeds.push_back('{32'h10000, 32'h30000, 0, 0, 0, 32'h20000});
    seeds.push_back('{32'h10000, -32'sh30000, 0, 0, 0, 32'h20000});
    seeds.push_back('{32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                      32'h7fffffff, 32'h7fffffff});
    seeds.push_back('{32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                      32'h80000000, 32'h80000000});
    seeds.push_back('{32'h7fffffff, 32'h80000000, 0, 0, 1, 32'h80000000});
    seeds.push_back('{32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, 1, 1});
    seeds.push_back('{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                      32'hffffffff, 32'hffffffff});
    seeds.push_back('{0, 0, 32'h80000000, 0, 32'h80000000, 0});
    seeds.push_back('{0, 0, 0, 32'h80000000, 0, 32'h80000000});
    seeds.push_back('{32'h12345678, 32'h9abcdef0, 32'h0fedcba9, 32'h87654321,
                      32'h00000003, 32'hfffffffd});
    foreach (seeds[i]) send_query(seeds[i]);

    // Random queries; no idling in the last stretch
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom - 100) calm = 1'b1;
      q.point_x = rand_coord();
      q.point_y = rand_coord();
      q.start_x = rand_coord();
      q.start_y = rand_coord();
      q.delta_x = ($urandom_range(0, 9) == 0) ? 32'h0 : rand_coord();
      q.delta_y = ($urandom_range(0, 9) == 0) ? 32'h0 : rand_coord();
      send_query(q);
    end
    in_valid_i <= 1'b0;
    sending_done = 1'b1;

    // Drain the pipeline
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("covered %0d queries, %0d result beats checked, idling on both sides",
             NumRandom + seeds.size(), board.checked);
    if (error_count == 0 && board.pending.size() == 0) begin
      $display("[point_segment_projection] OK");
    end else begin
      $display("[point_segment_projection] ERROR");
    end
    $finish;
  end

  // Timeout guard
  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[point_segment_projection] ERROR");
      $finish;
    end
  end

endmodule

>>> point_segment_projection.f
+incdir+sv
sv/psp_pkg.sv
sv/point_segment_projection.sv
verif/point_segment_projection_tb.sv
